// ===== src/art_pkg.sv =====
// Shared types and constants for the anti-replay tuple table.
// No dependencies; imported by every module under src.
package art_pkg;

  localparam int DEF_TABLE_ENTRIES = 8;

  localparam int SRC_W   = 16;
  localparam int ID_W    = 24;
  localparam int TUPLE_W = SRC_W + 2;
  localparam int ENTRY_W = TUPLE_W + ID_W;
  localparam int SLOT_W  = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } art_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } art_sts_t;

endpackage

// ===== src/art_ctrl.sv =====
// Controller state machine for the anti-replay tuple table.
// Depends on art_pkg; drives art_dpath through art_cmd_t and reads art_sts_t.
module art_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  art_pkg::art_sts_t sts,
  output art_pkg::art_cmd_t cmd
);
  import art_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_SCAN))
    else $error("request accepted without starting a scan");

  a_commit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (state_r == ST_IDLE && in_ready))
    else $error("commit did not return to idle");

endmodule

// ===== src/art_dpath.sv =====
// Datapath for the anti-replay tuple table: request registers, slot memory,
// valid bits, scan pipeline and output register. Depends on art_pkg.
module art_dpath #(
  parameter int TABLE_ENTRIES = art_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [art_pkg::SRC_W-1:0]   in_source_addr,
  input  logic                        in_dir_bit,
  input  logic                        in_key_sel,
  input  logic [art_pkg::ID_W-1:0]    in_message_id,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_accepted,
  output logic                        out_new_tuple,
  output logic                        out_evicted,
  output logic [art_pkg::SLOT_W-1:0]  out_slot_used,
  input  art_pkg::art_cmd_t           cmd,
  output art_pkg::art_sts_t           sts
);
  import art_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  logic [ENTRY_W-1:0]       mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;

  logic [TUPLE_W-1:0] tuple_r;
  logic [ID_W-1:0]    id_r;

  logic [IDX_W-1:0]   rd_idx_r;
  logic               rd_done_r;
  logic [IDX_W-1:0]   chk_idx_r;
  logic               chk_en_r;
  logic [ENTRY_W-1:0] rdata_r;

  logic               have_free_r;
  logic [IDX_W-1:0]   free_slot_r;
  logic               hit_r;
  logic [IDX_W-1:0]   hit_slot_r;
  logic               fresh_r;

  logic               out_valid_r;
  logic               out_accepted_r;
  logic               out_new_tuple_r;
  logic               out_evicted_r;
  logic [SLOT_W-1:0]  out_slot_r;

  logic                    check;
  logic                    entry_hit;
  logic                    is_last;
  logic [IDX_W-1:0]        slot;
  logic                    do_write;
  logic [IDX_W+SLOT_W-1:0] slot_ext;

  assign check     = cmd.scan && chk_en_r;
  assign entry_hit = valid_r[chk_idx_r] && (rdata_r[ENTRY_W-1:ID_W] == tuple_r);
  assign is_last   = (chk_idx_r == LAST_IDX);

  assign sts.scan_done = check && (entry_hit || is_last);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign slot     = hit_r ? hit_slot_r : (have_free_r ? free_slot_r : '0);
  assign do_write = cmd.commit && (!hit_r || fresh_r);
  assign slot_ext = {{SLOT_W{1'b0}}, slot};

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tuple_r <= {in_source_addr, in_dir_bit, in_key_sel};
      id_r    <= in_message_id;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_idx_r];
    if (do_write) begin
      mem[slot] <= {tuple_r, id_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_en_r    <= 1'b0;
      rd_done_r   <= 1'b0;
      rd_idx_r    <= '0;
      have_free_r <= 1'b0;
      hit_r       <= 1'b0;
    end else if (cmd.start) begin
      chk_en_r    <= 1'b0;
      rd_done_r   <= 1'b0;
      rd_idx_r    <= '0;
      have_free_r <= 1'b0;
      hit_r       <= 1'b0;
    end else if (cmd.scan) begin
      chk_idx_r <= rd_idx_r;
      chk_en_r  <= !rd_done_r;
      if (rd_idx_r == LAST_IDX) begin
        rd_done_r <= 1'b1;
      end else begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (check) begin
        if (!valid_r[chk_idx_r] && !have_free_r) begin
          have_free_r <= 1'b1;
          free_slot_r <= chk_idx_r;
        end
        if (entry_hit) begin
          hit_r      <= 1'b1;
          hit_slot_r <= chk_idx_r;
          fresh_r    <= (id_r > rdata_r[ID_W-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && !hit_r) begin
      valid_r[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_accepted_r  <= !hit_r || fresh_r;
      out_new_tuple_r <= !hit_r;
      out_evicted_r   <= !hit_r && !have_free_r;
      out_slot_r      <= slot_ext[SLOT_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_accepted  = out_accepted_r;
  assign out_new_tuple = out_new_tuple_r;
  assign out_evicted   = out_evicted_r;
  assign out_slot_used = out_slot_r;

  a_commit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before it was taken");

  a_evict_is_new: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_evicted_r || out_new_tuple_r))
    else $error("eviction flagged on a matched tuple");

  a_replay_not_new: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_accepted_r) |-> !out_new_tuple_r)
    else $error("replay flagged as new tuple");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> valid_r[$past(slot)])
    else $error("committed slot not marked valid");

endmodule

// ===== src/anti_replay_tuple_table.sv =====
// Top level of the anti-replay tuple table: controller plus datapath.
// Depends on art_pkg, art_ctrl and art_dpath.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------------
//   in      | in_valid / in_ready   | source_addr, dir_bit, key_sel, message_id
//   out     | out_valid / out_ready | accepted, new_tuple, evicted, slot_used
//
// One request at a time; the slot memory is scanned one entry per cycle through
// its registered read port. The scan stops at the first matching entry; a miss
// scans every entry before the commit.
// Synchronous active-low reset clears every valid bit and empties the output.
// A result waiting on out_ready does not block the next request; the commit of
// that next request holds until the output register is free.
module anti_replay_tuple_table #(
  parameter int TABLE_ENTRIES = art_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [art_pkg::SRC_W-1:0]   in_source_addr,
  input  logic                        in_dir_bit,
  input  logic                        in_key_sel,
  input  logic [art_pkg::ID_W-1:0]    in_message_id,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_accepted,
  output logic                        out_new_tuple,
  output logic                        out_evicted,
  output logic [art_pkg::SLOT_W-1:0]  out_slot_used
);
  import art_pkg::*;

  art_cmd_t cmd;
  art_sts_t sts;

  art_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  art_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_source_addr (in_source_addr),
    .in_dir_bit     (in_dir_bit),
    .in_key_sel     (in_key_sel),
    .in_message_id  (in_message_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_accepted   (out_accepted),
    .out_new_tuple  (out_new_tuple),
    .out_evicted    (out_evicted),
    .out_slot_used  (out_slot_used),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

// ===== dv/art_checker.sv =====
// Checker for the anti-replay tuple table: watches both channels, predicts each
// verdict from its own copy of the slot table and compares field by field.
// Depends on art_pkg for widths.
module art_checker #(
  parameter int TABLE_ENTRIES = art_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [art_pkg::SRC_W-1:0]  in_source_addr,
  input  logic                       in_dir_bit,
  input  logic                       in_key_sel,
  input  logic [art_pkg::ID_W-1:0]   in_message_id,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic                       out_accepted,
  input  logic                       out_new_tuple,
  input  logic                       out_evicted,
  input  logic [art_pkg::SLOT_W-1:0] out_slot_used,
  output int                         fails,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import art_pkg::*;

  typedef struct packed {
    logic              accepted;
    logic              new_tuple;
    logic              evicted;
    logic [SLOT_W-1:0] slot_used;
  } verdict_t;

  logic                slot_live   [TABLE_ENTRIES];
  logic [TUPLE_W-1:0]  slot_tuple  [TABLE_ENTRIES];
  logic [ID_W-1:0]     slot_last_id[TABLE_ENTRIES];
  verdict_t            verdict_q[$];

  function automatic verdict_t judge_frame(input logic [TUPLE_W-1:0] tuple,
                                           input logic [ID_W-1:0] msg_id);
    verdict_t v;
    int       open_slot;
    int       i;
    int       slot;
    v = '0;
    open_slot = -1;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (!slot_live[i]) begin
        if (open_slot < 0) open_slot = i;
      end else if (slot_tuple[i] == tuple) begin
        v.slot_used = i[SLOT_W-1:0];
        if (msg_id > slot_last_id[i]) begin
          slot_last_id[i] = msg_id;
          v.accepted = 1'b1;
        end
        return v;
      end
    end
    slot = (open_slot < 0) ? 0 : open_slot;
    slot_live[slot]    = 1'b1;
    slot_tuple[slot]   = tuple;
    slot_last_id[slot] = msg_id;
    v.accepted  = 1'b1;
    v.new_tuple = 1'b1;
    v.evicted   = (open_slot < 0);
    v.slot_used = slot[SLOT_W-1:0];
    return v;
  endfunction

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst_n) begin
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      verdict_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (out_accepted !== exp_v.accepted) begin
            $error("accepted: expected %0d, got %0d", exp_v.accepted, out_accepted);
            fails++;
          end
          if (out_new_tuple !== exp_v.new_tuple) begin
            $error("new_tuple: expected %0d, got %0d", exp_v.new_tuple, out_new_tuple);
            fails++;
          end
          if (out_evicted !== exp_v.evicted) begin
            $error("evicted: expected %0d, got %0d", exp_v.evicted, out_evicted);
            fails++;
          end
          if (out_slot_used !== exp_v.slot_used) begin
            $error("slot_used: expected %0d, got %0d", exp_v.slot_used, out_slot_used);
            fails++;
          end
        end
      end
      if (in_valid && in_ready)
        verdict_q.push_back(judge_frame({in_source_addr, in_dir_bit, in_key_sel},
                                        in_message_id));
    end
    pending = verdict_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the anti-replay tuple table testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on art_pkg, art_checker and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import art_pkg::*;

  localparam int POOL_SIZE     = 10;
  localparam int RANDOM_ITEMS  = 930;
  localparam int BLOCK_ITEMS   = 50;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 2 * (DEF_TABLE_ENTRIES + 3);

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [SRC_W-1:0]  in_source_addr;
  logic              in_dir_bit;
  logic              in_key_sel;
  logic [ID_W-1:0]   in_message_id;
  logic              out_valid;
  logic              out_ready;
  logic              out_accepted;
  logic              out_new_tuple;
  logic              out_evicted;
  logic [SLOT_W-1:0] out_slot_used;
  int                fails;
  int                pending;
  int                idle_cycles;
  bit                tx_fast;
  bit                rx_fast;

  logic [TUPLE_W-1:0] pool_tuple[POOL_SIZE];
  logic [ID_W-1:0]    pool_id[POOL_SIZE];

  anti_replay_tuple_table i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_source_addr (in_source_addr),
    .in_dir_bit     (in_dir_bit),
    .in_key_sel     (in_key_sel),
    .in_message_id  (in_message_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_accepted   (out_accepted),
    .out_new_tuple  (out_new_tuple),
    .out_evicted    (out_evicted),
    .out_slot_used  (out_slot_used)
  );

  art_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_source_addr (in_source_addr),
    .in_dir_bit     (in_dir_bit),
    .in_key_sel     (in_key_sel),
    .in_message_id  (in_message_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_accepted   (out_accepted),
    .out_new_tuple  (out_new_tuple),
    .out_evicted    (out_evicted),
    .out_slot_used  (out_slot_used),
    .fails          (fails),
    .pending        (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = rx_fast ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_request(input logic [SRC_W-1:0] src, input logic dir,
                              input logic key, input logic [ID_W-1:0] msg_id);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_source_addr <= src;
    in_dir_bit     <= dir;
    in_key_sel     <= key;
    in_message_id  <= msg_id;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_tuple(input logic [TUPLE_W-1:0] tuple, input logic [ID_W-1:0] msg_id);
    send_request(tuple[TUPLE_W-1:2], tuple[1], tuple[0], msg_id);
  endtask

  // hold the sender until every outstanding verdict has been returned
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int               sel;
    int               idx;
    logic [ID_W-1:0]  next_id;
    logic [TUPLE_W-1:0] fresh;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_source_addr = '0;
    in_dir_bit     = 1'b0;
    in_key_sel     = 1'b0;
    in_message_id  = '0;
    tx_fast        = 1'b0;
    rx_fast        = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_request(16'h0000, 1'b0, 1'b0, 24'h000000);
    send_request(16'h0000, 1'b0, 1'b0, 24'h000000);
    send_request(16'h0000, 1'b0, 1'b0, 24'h000001);
    send_request(16'hFFFF, 1'b1, 1'b1, 24'hFFFFFF);
    send_request(16'hFFFF, 1'b1, 1'b1, 24'hFFFFFF);
    send_request(16'hFFFF, 1'b1, 1'b1, 24'h000000);
    send_request(16'hFFFF, 1'b0, 1'b1, 24'h000005);
    send_request(16'hFFFF, 1'b1, 1'b0, 24'h000005);
    send_request(16'h0001, 1'b0, 1'b0, 24'h000064);
    send_request(16'h0002, 1'b0, 1'b0, 24'h000064);
    send_request(16'h0004, 1'b0, 1'b0, 24'h000064);
    send_request(16'h0008, 1'b0, 1'b0, 24'h000064);
    send_request(16'h0008, 1'b0, 1'b0, 24'h000065);
    send_request(16'h0008, 1'b0, 1'b0, 24'h000063);
    send_request(16'h8000, 1'b1, 1'b1, 24'h000007);
    send_request(16'h0000, 1'b0, 1'b0, 24'h000002);
    send_request(16'h0000, 1'b0, 1'b0, 24'h000002);
    send_request(16'hFFFF, 1'b1, 1'b0, 24'h000006);
    send_request(16'hAAAA, 1'b0, 1'b1, 24'h555555);
    send_request(16'h5555, 1'b1, 1'b0, 24'hAAAAAA);
    drain_results();

    foreach (pool_tuple[i]) begin
      pool_tuple[i] = TUPLE_W'($urandom_range(0, (1 << TUPLE_W) - 1));
      pool_id[i]    = ID_W'($urandom_range(0, 4096));
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BLOCK_ITEMS == 0) begin
        if (n % (4 * BLOCK_ITEMS) == 0) drain_results();
        tx_fast = ($urandom_range(0, 3) == 0);
        rx_fast = ($urandom_range(0, 3) == 0);
      end
      sel = $urandom_range(0, 99);
      idx = $urandom_range(0, POOL_SIZE - 1);
      if (sel < 75) begin
        sel = $urandom_range(0, 99);
        if (sel < 70)
          next_id = ID_W'(pool_id[idx] + $urandom_range(1, 4096));
        else if (sel < 85)
          next_id = pool_id[idx];
        else
          next_id = ID_W'($urandom());
        if (next_id > pool_id[idx]) pool_id[idx] = next_id;
        send_tuple(pool_tuple[idx], next_id);
      end else if (sel < 90) begin
        fresh = TUPLE_W'($urandom());
        send_tuple(fresh, ID_W'($urandom()));
      end else begin
        pool_tuple[idx] = TUPLE_W'($urandom());
        pool_id[idx]    = ID_W'($urandom_range(0, 65535));
        send_tuple(pool_tuple[idx], pool_id[idx]);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fails == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== anti_replay_tuple_table.f =====
src/art_pkg.sv
src/art_ctrl.sv
src/art_dpath.sv
src/anti_replay_tuple_table.sv
dv/art_checker.sv
dv/testbench.sv
